FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property templates for the block checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/gsc_pkg.sv
// ----------------------------------------------------------------------------
// gsc_pkg
// Types, constants and helpers shared by the greedy set cover modules.
// ----------------------------------------------------------------------------
package gsc_pkg;

   localparam int UNIV_BITS = 32;
   localparam int CNT_W     = $clog2(UNIV_BITS + 1);
   localparam int ID_W      = 8;
   localparam int USZ_W     = 6;

   localparam logic [USZ_W-1:0] USZ_RESET = USZ_W'(32);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_DRAIN,
      ST_PICK,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic scan_start;
      logic scan_rd;
      logic pick;
      logic empty;
      logic next_round;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic all_covered;
      logic scan_last;
      logic pipe_busy;
      logic rsp_last;
   } sts_type;

   function automatic logic [CNT_W-1:0] popcount(input logic [UNIV_BITS-1:0] v);
      logic [CNT_W-1:0] n;
      n = '0;
      for (int i = 0; i < UNIV_BITS; i++) begin
         n = n + CNT_W'(v[i]);
      end
      return n;
   endfunction

endpackage

FILE: hdl/gsc_ctrl.sv
// ----------------------------------------------------------------------------
// gsc_ctrl
// Sequencer for loading, per-round scans, picks and result transfers.
// ----------------------------------------------------------------------------
module gsc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_last_subset,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  gsc_pkg::sts_type  sts,
   output gsc_pkg::cmd_type  cmd
);

   gsc_pkg::state_type state_ff;
   gsc_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gsc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         gsc_pkg::ST_IDLE: begin
            req_stall = reset;
            if (req_valid && !reset) begin
               cmd.load = 1'b1;
               if (req_last_subset) begin
                  state_in = gsc_pkg::ST_CHECK;
               end
            end
         end
         gsc_pkg::ST_CHECK: begin
            if (sts.all_covered) begin
               cmd.empty = 1'b1;
               state_in  = gsc_pkg::ST_EMIT;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = gsc_pkg::ST_SCAN;
            end
         end
         gsc_pkg::ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (sts.scan_last) begin
               state_in = gsc_pkg::ST_DRAIN;
            end
         end
         gsc_pkg::ST_DRAIN: begin
            if (!sts.pipe_busy) begin
               state_in = gsc_pkg::ST_PICK;
            end
         end
         gsc_pkg::ST_PICK: begin
            cmd.pick = 1'b1;
            state_in = gsc_pkg::ST_EMIT;
         end
         gsc_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (sts.rsp_last) begin
                  cmd.finish = 1'b1;
                  state_in   = gsc_pkg::ST_IDLE;
               end else begin
                  cmd.next_round = 1'b1;
                  state_in       = gsc_pkg::ST_CHECK;
               end
            end
         end
         default: begin
            state_in = gsc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: hdl/gsc_dpath.sv
// ----------------------------------------------------------------------------
// gsc_dpath
// Subset store, coverage state, count pipeline, best-pick tracking and
// result register.
// ----------------------------------------------------------------------------
module gsc_dpath #(
   parameter int MAX_SUBSETS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [gsc_pkg::USZ_W-1:0]      csr_write_data,
   input  logic [gsc_pkg::ID_W-1:0]       req_subset_id,
   input  logic [gsc_pkg::UNIV_BITS-1:0]  req_member_mask,
   input  gsc_pkg::cmd_type               cmd,
   output gsc_pkg::sts_type               sts,
   output logic [gsc_pkg::ID_W-1:0]       rsp_chosen_id,
   output logic [gsc_pkg::CNT_W-1:0]      rsp_newly_covered,
   output logic                           rsp_cover_complete,
   output logic                           rsp_nothing_chosen,
   output logic                           rsp_last
);

   localparam int AW = (MAX_SUBSETS > 1) ? $clog2(MAX_SUBSETS) : 1;
   localparam int CW = $clog2(MAX_SUBSETS + 1);

   localparam int UB = gsc_pkg::UNIV_BITS;
   localparam int NW = gsc_pkg::CNT_W;
   localparam int IW = gsc_pkg::ID_W;

   logic [UB-1:0] mask_mem_ff [MAX_SUBSETS];
   logic [IW-1:0] id_mem_ff   [MAX_SUBSETS];

   logic [gsc_pkg::USZ_W-1:0] usize_ff;
   logic [CW-1:0]             count_ff;
   logic [UB-1:0]             covered_ff;
   logic [AW-1:0]             idx_ff;
   logic [AW-1:0]             round_ff;

   logic          rd_vld_ff;
   logic [UB-1:0] rd_mask_ff;
   logic [IW-1:0] rd_id_ff;

   logic          cnt_vld_ff;
   logic [NW-1:0] unc_ff;
   logic [NW-1:0] cov_ff;
   logic [IW-1:0] cid_ff;
   logic [UB-1:0] cmask_ff;

   logic          have_ff;
   logic [NW-1:0] best_unc_ff;
   logic [NW-1:0] best_cov_ff;
   logic [IW-1:0] best_id_ff;
   logic [UB-1:0] best_mask_ff;

   logic [UB-1:0] use_mask;
   logic [UB-1:0] rd_use;
   logic [UB-1:0] covered_in;
   logic          not_full;
   logic          round_last;
   logic          better;

   always_comb begin
      if (usize_ff >= gsc_pkg::USZ_W'(UB)) begin
         use_mask = '1;
      end else begin
         use_mask = (UB'(1) << usize_ff) - UB'(1);
      end
   end

   assign rd_use     = rd_mask_ff & use_mask;
   assign covered_in = covered_ff | (best_mask_ff & use_mask);
   assign not_full   = (count_ff != CW'(MAX_SUBSETS));
   assign round_last = (CW'(round_ff) == (count_ff - CW'(1)));

   always_comb begin
      if (!have_ff) begin
         better = 1'b1;
      end else if (unc_ff != best_unc_ff) begin
         better = (unc_ff > best_unc_ff);
      end else if (cov_ff != best_cov_ff) begin
         better = (cov_ff < best_cov_ff);
      end else begin
         better = (cid_ff < best_id_ff);
      end
   end

   assign sts.all_covered = ((covered_ff & use_mask) == use_mask);
   assign sts.scan_last   = (CW'(idx_ff) == (count_ff - CW'(1)));
   assign sts.pipe_busy   = rd_vld_ff;
   assign sts.rsp_last    = rsp_last;

   // subset store
   always_ff @(posedge clock) begin
      if (cmd.load && not_full) begin
         mask_mem_ff[count_ff[AW-1:0]] <= req_member_mask;
         id_mem_ff[count_ff[AW-1:0]]   <= req_subset_id;
      end
      if (cmd.scan_rd) begin
         rd_mask_ff <= mask_mem_ff[idx_ff];
         rd_id_ff   <= id_mem_ff[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         usize_ff   <= gsc_pkg::USZ_RESET;
         count_ff   <= '0;
         covered_ff <= '0;
         idx_ff     <= '0;
         round_ff   <= '0;
         rd_vld_ff  <= 1'b0;
         cnt_vld_ff <= 1'b0;
         have_ff    <= 1'b0;
      end else begin
         rd_vld_ff  <= cmd.scan_rd;
         cnt_vld_ff <= rd_vld_ff;
         if (csr_write_enable) begin
            usize_ff <= csr_write_data;
         end
         if (cmd.load && not_full) begin
            count_ff <= count_ff + CW'(1);
         end
         if (cmd.scan_start) begin
            idx_ff  <= '0;
            have_ff <= 1'b0;
         end else if (cmd.scan_rd) begin
            idx_ff <= idx_ff + AW'(1);
         end
         if (cnt_vld_ff && better) begin
            have_ff <= 1'b1;
         end
         if (cmd.pick) begin
            covered_ff <= covered_in;
         end
         if (cmd.next_round) begin
            round_ff <= round_ff + AW'(1);
         end
         if (cmd.finish) begin
            count_ff   <= '0;
            covered_ff <= '0;
            round_ff   <= '0;
         end
      end
   end

   // count stage and best tracking
   always_ff @(posedge clock) begin
      unc_ff   <= gsc_pkg::popcount(rd_use & ~covered_ff);
      cov_ff   <= gsc_pkg::popcount(rd_use & covered_ff);
      cid_ff   <= rd_id_ff;
      cmask_ff <= rd_mask_ff;
      if (cnt_vld_ff && better) begin
         best_unc_ff  <= unc_ff;
         best_cov_ff  <= cov_ff;
         best_id_ff   <= cid_ff;
         best_mask_ff <= cmask_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.pick) begin
         rsp_chosen_id      <= best_id_ff;
         rsp_newly_covered  <= best_unc_ff;
         rsp_cover_complete <= ((covered_in & use_mask) == use_mask);
         rsp_nothing_chosen <= 1'b0;
         rsp_last           <= ((covered_in & use_mask) == use_mask) || round_last;
      end else if (cmd.empty) begin
         rsp_chosen_id      <= '0;
         rsp_newly_covered  <= '0;
         rsp_cover_complete <= 1'b0;
         rsp_nothing_chosen <= 1'b1;
         rsp_last           <= 1'b1;
      end
   end

endmodule

FILE: hdl/greedy_set_cover.sv
// ----------------------------------------------------------------------------
// greedy_set_cover
// Greedy set cover engine: stores subsets, then emits one pick per round.
// ----------------------------------------------------------------------------
// Load transfers are accepted while the engine is idle; the one marked
// last_subset starts a run, during which req_stall stays high. With n stored
// subsets a round is one coverage check, a scan that reads one subset per
// cycle from the single read port of the subset store, a drain of the count
// pipeline, one pick and one result transfer, which waits out any rsp_stall.
// A run has at most n rounds; an already covered universe gives one result,
// with nothing chosen.
module greedy_set_cover #(
   parameter int MAX_SUBSETS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [gsc_pkg::USZ_W-1:0]      csr_write_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [gsc_pkg::ID_W-1:0]       req_subset_id,
   input  logic [gsc_pkg::UNIV_BITS-1:0]  req_member_mask,
   input  logic                           req_last_subset,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [gsc_pkg::ID_W-1:0]       rsp_chosen_id,
   output logic [gsc_pkg::CNT_W-1:0]      rsp_newly_covered,
   output logic                           rsp_cover_complete,
   output logic                           rsp_nothing_chosen,
   output logic                           rsp_last
);

   gsc_pkg::cmd_type cmd;
   gsc_pkg::sts_type sts;

   gsc_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_last_subset (req_last_subset),
      .req_stall       (req_stall),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .sts             (sts),
      .cmd             (cmd)
   );

   gsc_dpath #(
      .MAX_SUBSETS (MAX_SUBSETS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_subset_id      (req_subset_id),
      .req_member_mask    (req_member_mask),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_chosen_id      (rsp_chosen_id),
      .rsp_newly_covered  (rsp_newly_covered),
      .rsp_cover_complete (rsp_cover_complete),
      .rsp_nothing_chosen (rsp_nothing_chosen),
      .rsp_last           (rsp_last)
   );

endmodule

FILE: hdl/gsc_checker.sv
// ----------------------------------------------------------------------------
// gsc_assertions
// Port-level checks for greedy_set_cover, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gsc_assertions (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [gsc_pkg::ID_W-1:0]       rsp_chosen_id,
   input logic [gsc_pkg::CNT_W-1:0]      rsp_newly_covered,
   input logic                           rsp_cover_complete,
   input logic                           rsp_nothing_chosen,
   input logic                           rsp_last
);

   logic empty_rsp;
   logic empty_ok;
   logic done_rsp;

   assign empty_rsp = rsp_valid && rsp_nothing_chosen;
   assign empty_ok  = rsp_last && !rsp_cover_complete && (rsp_chosen_id == '0) &&
                      (rsp_newly_covered == '0);
   assign done_rsp  = rsp_valid && rsp_cover_complete;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result withdrawn")
   `ASSERT_IMPLY(a_busy_run, clock, reset, rsp_valid, req_stall, "load taken during a run")
   `ASSERT_IMPLY(a_empty_last, clock, reset, empty_rsp, empty_ok, "bad empty result")
   `ASSERT_IMPLY(a_done_last, clock, reset, done_rsp, rsp_last, "complete cover not last")

endmodule

bind greedy_set_cover gsc_assertions u_gsc_assertions (.*);

FILE: sim/gsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsc_checker
// Watches the load, result and register ports of the greedy set cover engine,
// keeps its own copy of the subset store and the universe size, predicts the
// picks of each cover run when its final subset transfers, and compares every
// result transfer field by field against the oldest predicted pick.
// ----------------------------------------------------------------------------
module gsc_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [gsc_pkg::USZ_W-1:0]      csr_write_data,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [gsc_pkg::ID_W-1:0]       req_subset_id,
   input  logic [gsc_pkg::UNIV_BITS-1:0]  req_member_mask,
   input  logic                           req_last_subset,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [gsc_pkg::ID_W-1:0]       rsp_chosen_id,
   input  logic [gsc_pkg::CNT_W-1:0]      rsp_newly_covered,
   input  logic                           rsp_cover_complete,
   input  logic                           rsp_nothing_chosen,
   input  logic                           rsp_last,
   output int unsigned                    mismatch_count,
   output int unsigned                    pending_picks,
   output int unsigned                    runs_started,
   output int unsigned                    picks_checked
);

   localparam int STORE_DEPTH  = 16;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [gsc_pkg::ID_W-1:0]  chosen_id;
      logic [gsc_pkg::CNT_W-1:0] newly_covered;
      logic                      cover_complete;
      logic                      nothing_chosen;
      logic                      last;
   } pick_result_type;

   logic [gsc_pkg::UNIV_BITS-1:0] stored_masks [STORE_DEPTH];
   logic [gsc_pkg::ID_W-1:0]      stored_ids [STORE_DEPTH];
   int unsigned                   stored_count;
   logic [gsc_pkg::USZ_W-1:0]     universe_size;
   pick_result_type               expected_picks [$];

   function automatic int unsigned count_ones(input logic [gsc_pkg::UNIV_BITS-1:0] v);
      int unsigned n;
      n = 0;
      for (int i = 0; i < gsc_pkg::UNIV_BITS; i++)
         n += v[i];
      return n;
   endfunction

   function automatic void predict_picks();
      logic [gsc_pkg::UNIV_BITS-1:0] in_use;
      logic [gsc_pkg::UNIV_BITS-1:0] covered;
      logic [gsc_pkg::UNIV_BITS-1:0] members;
      int unsigned                   width;
      int unsigned                   best;
      int unsigned                   best_unc;
      int unsigned                   best_cov;
      int unsigned                   unc;
      int unsigned                   cov;
      int unsigned                   rounds;
      bit                            better;
      pick_result_type               res;
      width = (universe_size > gsc_pkg::UNIV_BITS) ? gsc_pkg::UNIV_BITS : universe_size;
      in_use = (width == gsc_pkg::UNIV_BITS) ? '1 : ((32'd1 << width) - 32'd1);
      covered = '0;
      rounds = 0;
      for (int unsigned r = 0; r < stored_count; r++) begin
         if ((covered & in_use) == in_use)
            break;
         best = 0;
         best_unc = 0;
         best_cov = 0;
         for (int unsigned k = 0; k < stored_count; k++) begin
            members = stored_masks[k] & in_use;
            unc = count_ones(members & ~covered);
            cov = count_ones(members & covered);
            if (k == 0)
               better = 1'b1;
            else if (unc != best_unc)
               better = unc > best_unc;
            else if (cov != best_cov)
               better = cov < best_cov;
            else
               better = stored_ids[k] < stored_ids[best];
            if (better) begin
               best = k;
               best_unc = unc;
               best_cov = cov;
            end
         end
         covered |= stored_masks[best] & in_use;
         res.chosen_id = stored_ids[best];
         res.newly_covered = gsc_pkg::CNT_W'(best_unc);
         res.cover_complete = ((covered & in_use) == in_use);
         res.nothing_chosen = 1'b0;
         // final pick: cover done or rounds used up
         res.last = res.cover_complete || (r == stored_count - 1);
         expected_picks = {expected_picks, res};
         rounds++;
      end
      if (rounds == 0) begin
         res = '0;
         res.nothing_chosen = 1'b1;
         res.last = 1'b1;
         expected_picks = {expected_picks, res};
      end
   endfunction

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         if (mismatch_count < REPORT_LIMIT)
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      pick_result_type want;
      if (reset) begin
         stored_count = 0;
         universe_size = gsc_pkg::USZ_RESET;
         expected_picks.delete();
         mismatch_count = 0;
         runs_started = 0;
         picks_checked = 0;
      end else begin
         if (csr_write_enable)
            universe_size = csr_write_data;
         if (req_valid && !req_stall) begin
            // drop loads once the store is full
            if (stored_count < STORE_DEPTH) begin
               stored_ids[stored_count] = req_subset_id;
               stored_masks[stored_count] = req_member_mask;
               stored_count++;
            end
            if (req_last_subset) begin
               predict_picks();
               stored_count = 0;
               runs_started++;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_picks.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT)
                  $display("%0t: result transfer with no pick expected, chosen_id %0d",
                           $time, rsp_chosen_id);
               mismatch_count++;
            end else begin
               want = expected_picks.pop_front();
               check_field("chosen_id", want.chosen_id, rsp_chosen_id);
               check_field("newly_covered", want.newly_covered, rsp_newly_covered);
               check_field("cover_complete", want.cover_complete, rsp_cover_complete);
               check_field("nothing_chosen", want.nothing_chosen, rsp_nothing_chosen);
               check_field("last", want.last, rsp_last);
               picks_checked++;
            end
         end
      end
      pending_picks = expected_picks.size();
   end

endmodule

FILE: sim/tb_greedy_set_cover.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_greedy_set_cover
// Drives subset loads and universe size writes into the greedy set cover
// engine: a directed set of runs for ties, empty and full masks, an already
// covered universe and out-of-range sizes, then random runs, some past the
// store depth, under random stall bursts and one long result hold. Picks are
// checked by gsc_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_greedy_set_cover;

   localparam int ITEM_TARGET   = 320;
   localparam int QUIET_ITEMS   = 50;
   localparam int PHASE_ITEMS   = 35;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 40;
   localparam int LONG_HOLD     = 400;
   localparam int STALL_LIMIT   = 3000;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           csr_write_enable;
   logic [gsc_pkg::USZ_W-1:0]      csr_write_data;
   logic                           req_valid;
   logic                           req_stall;
   logic [gsc_pkg::ID_W-1:0]       req_subset_id;
   logic [gsc_pkg::UNIV_BITS-1:0]  req_member_mask;
   logic                           req_last_subset;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic [gsc_pkg::ID_W-1:0]       rsp_chosen_id;
   logic [gsc_pkg::CNT_W-1:0]      rsp_newly_covered;
   logic                           rsp_cover_complete;
   logic                           rsp_nothing_chosen;
   logic                           rsp_last;

   int unsigned mismatch_count;
   int unsigned pending_picks;
   int unsigned runs_started;
   int unsigned picks_checked;

   int unsigned items_sent;
   int unsigned overflow_runs;
   int unsigned idle_cycles;
   int unsigned phase_sizes [9] = '{32, 8, 0, 63, 1, 33, 20, 5, 32};
   bit          quiet;
   bit          long_hold;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   greedy_set_cover u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_subset_id      (req_subset_id),
      .req_member_mask    (req_member_mask),
      .req_last_subset    (req_last_subset),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_chosen_id      (rsp_chosen_id),
      .rsp_newly_covered  (rsp_newly_covered),
      .rsp_cover_complete (rsp_cover_complete),
      .rsp_nothing_chosen (rsp_nothing_chosen),
      .rsp_last           (rsp_last)
   );

   gsc_checker u_checker (.*);

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side: long hold on request, else random stall bursts
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_stall = 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            rsp_stall = 1'b0;
            long_hold = 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 13)) @(negedge clock);
            rsp_stall = 1'b0;
         end else begin
            repeat ($urandom_range(0, 20)) @(negedge clock);
         end
      end
   end

   task automatic send_item(input logic [gsc_pkg::ID_W-1:0] id,
                            input logic [gsc_pkg::UNIV_BITS-1:0] mask,
                            input logic last_flag);
      req_subset_id = id;
      req_member_mask = mask;
      req_last_subset = last_flag;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic idle_req(input int unsigned cycles);
      req_valid = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic set_universe(input logic [gsc_pkg::USZ_W-1:0] size);
      req_valid = 1'b0;
      while (pending_picks != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data = size;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic send_random_run(input int unsigned count);
      logic [gsc_pkg::UNIV_BITS-1:0] mask;
      logic [gsc_pkg::UNIV_BITS-1:0] prev_mask;
      logic [gsc_pkg::ID_W-1:0]      id;
      prev_mask = $urandom;
      if (count > 16)
         overflow_runs++;
      for (int unsigned i = 0; i < count; i++) begin
         if (!quiet && $urandom_range(0, 3) == 0)
            idle_req($urandom_range(1, 13));
         case ($urandom_range(0, 7))
            0: mask = '0;
            1: mask = '1;
            2: mask = $urandom & $urandom;
            3: mask = 32'd1 << $urandom_range(0, 31);
            4: mask = prev_mask;
            default: mask = $urandom;
         endcase
         // narrow id range to force id tie breaks
         id = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 3));
         send_item(id, mask, i == count - 1);
         prev_mask = mask;
      end
   endtask

   initial begin
      int unsigned phase;
      int unsigned phase_items;
      int unsigned run_len;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_subset_id = '0;
      req_member_mask = '0;
      req_last_subset = 1'b0;
      items_sent = 0;
      overflow_runs = 0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      set_universe(6'd32);
      send_item(8'hFF, 32'hFFFF_FFFF, 1'b1);
      send_item(8'h00, 32'h0000_0000, 1'b0);
      send_item(8'h05, 32'h0000_0000, 1'b1);
      send_item(8'h07, 32'h0000_00FF, 1'b0);
      send_item(8'h03, 32'h0000_FF00, 1'b0);
      send_item(8'h09, 32'h00FF_0000, 1'b0);
      send_item(8'h02, 32'h0000_00FF, 1'b0);
      send_item(8'h04, 32'hFF00_0000, 1'b1);
      send_item(8'h11, 32'h5555_5555, 1'b0);
      send_item(8'h22, 32'hAAAA_AAAA, 1'b0);
      send_item(8'h33, 32'hFFFF_0000, 1'b1);
      set_universe(6'd16);
      send_item(8'h05, 32'h0000_00FF, 1'b0);
      send_item(8'h01, 32'h0000_0F0F, 1'b0);
      send_item(8'h03, 32'h0000_F00F, 1'b0);
      send_item(8'h04, 32'h0000_F000, 1'b1);
      set_universe(6'd0);
      send_item(8'h01, 32'hFFFF_FFFF, 1'b1);
      set_universe(6'd1);
      send_item(8'h80, 32'hFFFF_FFFE, 1'b0);
      send_item(8'h7F, 32'h0000_0001, 1'b1);
      set_universe(6'd63);
      send_item(8'h55, 32'h8000_0001, 1'b0);
      send_item(8'hAA, 32'h7FFF_FFFE, 1'b1);

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         set_universe(gsc_pkg::USZ_W'(phase < 9 ? phase_sizes[phase]
                                                : $urandom_range(1, 32)));
         if (phase == 0) begin
            // hold results back while loads keep coming
            long_hold = 1'b1;
            send_random_run(4);
            send_random_run(4);
         end
         phase_items = 0;
         while (phase_items < PHASE_ITEMS && items_sent < ITEM_TARGET) begin
            quiet = (items_sent + QUIET_ITEMS >= ITEM_TARGET);
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20)
                                                  : $urandom_range(1, 6);
            send_random_run(run_len);
            phase_items += run_len;
         end
         phase++;
      end

      req_valid = 1'b0;
      while (pending_picks != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Covered %0d subset transfers in %0d cover runs (%0d overfilled the store),",
               items_sent, runs_started, overflow_runs);
      $display("%0d picks checked over %0d universe size settings", picks_checked, phase + 5);
      if (mismatch_count == 0 && pending_picks == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches, %0d picks outstanding", mismatch_count, pending_picks);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
